### rtl/tlsc_pkg.sv
// Shared types, codes and constants of the timed light session unit.
package tlsc_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W      = 32;
    localparam int BATT_W      = 7;
    localparam int TEMP_W      = 8;
    localparam int BRIGHT_W    = 8;
    localparam int LEVEL_W     = 4;
    localparam int STATUS_W    = 3;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // two-entry queue between front and back
    localparam int PQ_DEPTH    = 2;
    localparam int PQ_PTR_W    = 1;
    localparam int PQ_CNT_W    = 2;

    localparam logic [BRIGHT_W-1:0] FULL_BRIGHT = 8'd255;

    localparam logic [BATT_W-1:0]        RST_MIN_BATT = 7'd10;
    localparam logic signed [TEMP_W-1:0] RST_MIN_TEMP = 8'sd0;
    localparam logic signed [TEMP_W-1:0] RST_MAX_TEMP = 8'sd45;
    localparam logic [TIME_W-1:0]        RST_MAX_ON   = 32'd60000;

    typedef enum logic [KIND_W-1:0] {
        EV_START,
        EV_TICK,
        EV_STOP,
        EV_TAKE
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_POWER,
        ST_BATT_LOW,
        ST_TEMP,
        ST_RUNNING,
        ST_Q_FULL,
        ST_IDLE
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CR_MIN_BATT,
        CR_MIN_TEMP,
        CR_MAX_TEMP,
        CR_MAX_ON
    } cfg_reg_t;

    typedef struct packed {
        logic [BATT_W-1:0] min_batt;
        logic [TEMP_W-1:0] min_temp;
        logic [TEMP_W-1:0] max_temp;
        logic [TIME_W-1:0] max_on;
    } cfg_t;

    // classified event word handed from front to back
    typedef struct packed {
        kind_t               kind;
        status_t             pre_status;
        logic [TIME_W-1:0]   now_ms;
        logic [BRIGHT_W-1:0] restore;
    } cls_t;

    typedef struct packed {
        logic valid;
        cls_t word;
    } cls_push_t;

endpackage

### rtl/tlsc_evt_if.sv
// Event channel: valid/ready plus the event fields.
interface tlsc_evt_if import tlsc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [TIME_W-1:0]          now_ms;
    logic [BATT_W-1:0]          charge_pct;
    logic signed [TEMP_W-1:0]   temp_deg;
    logic                       power_valid;
    logic [BRIGHT_W-1:0]        brightness_to_restore;

    modport source (
        output valid, kind, now_ms, charge_pct, temp_deg, power_valid,
               brightness_to_restore,
        input  ready
    );
    modport sink (
        input  valid, kind, now_ms, charge_pct, temp_deg, power_valid,
               brightness_to_restore,
        output ready
    );
endinterface

### rtl/tlsc_res_if.sv
// Result channel: valid/ready plus the result fields.
interface tlsc_res_if import tlsc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   accepted;
    logic [STATUS_W-1:0]    status;
    logic                   light_on;
    logic                   cmd_valid;
    logic [BRIGHT_W-1:0]    cmd_brightness;
    logic [LEVEL_W-1:0]     queue_level;

    modport source (
        output valid, accepted, status, light_on, cmd_valid, cmd_brightness, queue_level,
        input  ready
    );
    modport sink (
        input  valid, accepted, status, light_on, cmd_valid, cmd_brightness, queue_level,
        output ready
    );
endinterface

### rtl/tlsc_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
interface tlsc_cfg_if import tlsc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/timed_light_session_with_command_fifo_unit.sv
// Path: an event word taken at the input is written into the two-entry queue; the back
//   end takes it from there and registers its result word, which is held until accepted.
// Throughput: one event word per cycle while results are taken and the queue has room;
//   the back end updates session state and the command queue for one event at a time.
// Reset (rst_n low, asynchronous): session off, times and pointers zero, command
//   queue empty, registers at their defaults; queued command slots are not cleared.
module timed_light_session_with_command_fifo_unit import tlsc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tlsc_evt_if.sink    evt,
    tlsc_res_if.source  res,
    tlsc_cfg_if.sink    cfg
);
    // live configuration, shared by front checks and back timeout
    cfg_t       regs;

    // front -> queue
    cls_push_t  push;
    logic       push_ready;

    // queue -> back
    logic       pop_valid;
    cls_t       pop_word;
    logic       pop_ready;

    tlsc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Front: power, battery and temperature checks need no session state, so they
    // run as the word is taken and travel with it.
    tlsc_front u_front (
        .evt        (evt),
        .regs       (regs),
        .push       (push),
        .push_ready (push_ready)
    );

    // Short queue: lets the input keep taking words while a result is stalled.
    tlsc_pipe_q u_pipe_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_word   (pop_word),
        .pop_ready  (pop_ready)
    );

    // Back: running check, timeout compare, command queue push/pop, result register.
    tlsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .regs     (regs),
        .in_valid (pop_valid),
        .w        (pop_word),
        .in_ready (pop_ready),
        .res      (res)
    );

`ifndef NO_ASSERTIONS
    // a popped command always means a successful event
    a_cmd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.cmd_valid |-> res.accepted && res.status == ST_OK)
        else $error("cmd_valid without ok status");

    // brightness field is zero unless a command was popped
    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.cmd_valid |-> res.cmd_brightness == '0)
        else $error("cmd_brightness set without command");

    // queue level never passes the queue depth
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.queue_level <= LEVEL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    // accepted and status agree
    a_acc: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.accepted == (res.status == ST_OK))
        else $error("accepted disagrees with status");
`endif
endmodule

### rtl/tlsc_cfg_regs.sv
// Configuration register bank.
module tlsc_cfg_regs import tlsc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tlsc_cfg_if.sink    cfg,
    output cfg_t        regs
);
    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.min_batt <= RST_MIN_BATT;
            regs_reg.min_temp <= RST_MIN_TEMP;
            regs_reg.max_temp <= RST_MAX_TEMP;
            regs_reg.max_on   <= RST_MAX_ON;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CR_MIN_BATT: regs_reg.min_batt <= cfg.data[BATT_W-1:0];
                CR_MIN_TEMP: regs_reg.min_temp <= cfg.data[TEMP_W-1:0];
                CR_MAX_TEMP: regs_reg.max_temp <= cfg.data[TEMP_W-1:0];
                CR_MAX_ON:   regs_reg.max_on   <= cfg.data[TIME_W-1:0];
            endcase
        end
    end
endmodule

### rtl/tlsc_front.sv
// Front end: takes event words and runs the state-free start checks.
module tlsc_front import tlsc_pkg::*; (
    tlsc_evt_if.sink    evt,
    input  cfg_t        regs,
    output cls_push_t   push,
    input  logic        push_ready
);
    status_t pre;

    // power, then battery, then temperature window
    always_comb
    begin
        priority if (!evt.power_valid)
            pre = ST_POWER;
        else if (evt.charge_pct < regs.min_batt)
            pre = ST_BATT_LOW;
        else if ($signed(evt.temp_deg) < $signed(regs.min_temp) ||
                 $signed(evt.temp_deg) > $signed(regs.max_temp))
            pre = ST_TEMP;
        else
            pre = ST_OK;
    end

    assign push.valid           = evt.valid;
    assign push.word.kind       = kind_t'(evt.kind);
    assign push.word.pre_status = pre;
    assign push.word.now_ms     = evt.now_ms;
    assign push.word.restore    = evt.brightness_to_restore;
    assign evt.ready            = push_ready;
endmodule

### rtl/tlsc_pipe_q.sv
// Two-entry word queue between front and back.
module tlsc_pipe_q import tlsc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cls_push_t   push,
    output logic        push_ready,
    output logic        pop_valid,
    output cls_t        pop_word,
    input  logic        pop_ready
);
    cls_t                 entry_reg [PQ_DEPTH];
    logic [PQ_PTR_W-1:0]  wr_reg;
    logic [PQ_PTR_W-1:0]  rd_reg;
    logic [PQ_CNT_W-1:0]  cnt_reg;
    logic [PQ_CNT_W-1:0]  cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (cnt_reg != PQ_CNT_W'(PQ_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_word   = entry_reg[rd_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_reg] <= push.word;
    end
endmodule

### rtl/tlsc_back.sv
// Back end: session state, brightness command queue and result register.
module tlsc_back import tlsc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        regs,
    input  logic        in_valid,
    input  cls_t        w,
    output logic        in_ready,
    tlsc_res_if.source  res
);
    logic                 session_reg,  session_next;
    logic [TIME_W-1:0]    start_reg,    start_next;
    logic [BRIGHT_W-1:0]  saved_reg,    saved_next;
    logic [QPTR_W-1:0]    wptr_reg,     wptr_next;
    logic [QPTR_W-1:0]    rptr_reg,     rptr_next;
    logic [QCNT_W-1:0]    fill_reg,     fill_next;
    logic [BRIGHT_W-1:0]  store_reg [QUEUE_DEPTH];

    logic                 out_valid_reg;
    logic                 out_ok_reg;
    status_t              out_status_reg;
    logic                 out_light_reg;
    logic                 out_cv_reg;
    logic [BRIGHT_W-1:0]  out_cb_reg;
    logic [QCNT_W-1:0]    out_fill_reg;

    logic                 fire;
    logic                 q_full;
    logic                 q_empty;
    logic [TIME_W-1:0]    elapsed;
    logic                 end_req;
    logic                 push_en;
    logic [BRIGHT_W-1:0]  push_val;
    logic                 ok;
    status_t              st;
    logic                 cv;
    logic [BRIGHT_W-1:0]  cb;

    assign in_ready = !out_valid_reg || res.ready;
    assign fire     = in_valid && in_ready;
    assign q_full   = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty  = (fill_reg == '0);
    assign elapsed  = w.now_ms - start_reg;

    always_comb
    begin
        session_next = session_reg;
        start_next   = start_reg;
        saved_next   = saved_reg;
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        fill_next    = fill_reg;
        push_en      = 1'b0;
        push_val     = saved_reg;
        end_req      = 1'b0;
        ok           = 1'b0;
        st           = ST_IDLE;
        cv           = 1'b0;
        cb           = '0;

        unique case (w.kind)
            EV_START:
            begin
                priority if (session_reg)
                    st = ST_RUNNING;
                else if (w.pre_status != ST_OK)
                    st = w.pre_status;
                else if (q_full)
                    st = ST_Q_FULL;
                else
                begin
                    push_en      = 1'b1;
                    push_val     = FULL_BRIGHT;
                    session_next = 1'b1;
                    start_next   = w.now_ms;
                    saved_next   = w.restore;
                    ok           = 1'b1;
                    st           = ST_OK;
                end
            end
            EV_TICK:
                end_req = session_reg && (elapsed >= regs.max_on);
            EV_STOP:
                end_req = session_reg;
            EV_TAKE:
            begin
                if (!q_empty)
                begin
                    rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rptr_reg + 1'b1;
                    fill_next = fill_reg - 1'b1;
                    cv        = 1'b1;
                    cb        = store_reg[rptr_reg];
                    ok        = 1'b1;
                    st        = ST_OK;
                end
            end
        endcase

        // session ends even when the restore command cannot be queued
        if (end_req)
        begin
            session_next = 1'b0;
            if (q_full)
                st = ST_Q_FULL;
            else
            begin
                push_en = 1'b1;
                ok      = 1'b1;
                st      = ST_OK;
            end
        end

        if (push_en)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg   <= 1'b0;
            start_reg     <= '0;
            saved_reg     <= '0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                session_reg   <= session_next;
                start_reg     <= start_next;
                saved_reg     <= saved_next;
                wptr_reg      <= wptr_next;
                rptr_reg      <= rptr_next;
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_ok_reg     <= ok;
            out_status_reg <= st;
            out_light_reg  <= session_next;
            out_cv_reg     <= cv;
            out_cb_reg     <= cb;
            out_fill_reg   <= fill_next;
            if (push_en)
                store_reg[wptr_reg] <= push_val;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.accepted       = out_ok_reg;
    assign res.status         = out_status_reg;
    assign res.light_on       = out_light_reg;
    assign res.cmd_valid      = out_cv_reg;
    assign res.cmd_brightness = out_cb_reg;
    assign res.queue_level    = LEVEL_W'(out_fill_reg);
endmodule

### tb/sv/tlsc_outcome_checker.sv
// Watches the event, result and register channels, predicts each result word and compares.
module tlsc_outcome_checker import tlsc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    tlsc_evt_if     evt,
    tlsc_res_if     res,
    tlsc_cfg_if     cfg,
    output int      errors,
    output int      pending
);

    typedef struct packed {
        logic                accepted;
        status_t             status;
        logic                light_on;
        logic                cmd_valid;
        logic [BRIGHT_W-1:0] cmd_brightness;
        logic [LEVEL_W-1:0]  queue_level;
    } outcome_t;

    // predicted session and command queue
    logic                       session_on;
    logic [TIME_W-1:0]          session_start;
    logic [BRIGHT_W-1:0]        restore_level;
    logic [BRIGHT_W-1:0]        cmd_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]          rd_idx;
    logic [QPTR_W-1:0]          wr_idx;
    logic [QCNT_W-1:0]          cmd_count;

    // register copies
    logic [BATT_W-1:0]          lim_batt;
    logic signed [TEMP_W-1:0]   lim_tmin;
    logic signed [TEMP_W-1:0]   lim_tmax;
    logic [TIME_W-1:0]          lim_on;

    outcome_t outcomes_due [$];

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
    endtask

    task automatic push_cmd(input logic [BRIGHT_W-1:0] value, output logic pushed);
        pushed = 1'b0;
        if (cmd_count < QUEUE_DEPTH) begin
            cmd_mem[wr_idx] = value;
            wr_idx    = (wr_idx == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
            cmd_count = cmd_count + 1'b1;
            pushed    = 1'b1;
        end
    endtask

    // stop or timeout: session ends even when the restore command has no room
    task automatic end_session(inout outcome_t o);
        logic pushed;
        session_on = 1'b0;
        push_cmd(restore_level, pushed);
        o.accepted = pushed;
        o.status   = pushed ? ST_OK : ST_Q_FULL;
    endtask

    task automatic predict_event(input kind_t k, input logic [TIME_W-1:0] now,
                                 input logic [BATT_W-1:0] batt,
                                 input logic signed [TEMP_W-1:0] temp,
                                 input logic pwr, input logic [BRIGHT_W-1:0] restore,
                                 output outcome_t o);
        logic pushed;
        o        = '0;
        o.status = ST_IDLE;
        case (k)
            EV_START: begin
                if (session_on)
                    o.status = ST_RUNNING;
                else if (!pwr)
                    o.status = ST_POWER;
                else if (batt < lim_batt)
                    o.status = ST_BATT_LOW;
                else if (temp < lim_tmin || temp > lim_tmax)
                    o.status = ST_TEMP;
                else begin
                    push_cmd(FULL_BRIGHT, pushed);
                    if (!pushed)
                        o.status = ST_Q_FULL;
                    else begin
                        session_on    = 1'b1;
                        session_start = now;
                        restore_level = restore;
                        o.accepted    = 1'b1;
                        o.status      = ST_OK;
                    end
                end
            end
            EV_TICK: begin
                // elapsed time wraps at 32 bits
                if (session_on && (now - session_start) >= lim_on)
                    end_session(o);
            end
            EV_STOP: begin
                if (session_on)
                    end_session(o);
            end
            default: begin
                if (cmd_count != 0) begin
                    o.cmd_brightness = cmd_mem[rd_idx];
                    rd_idx    = (rd_idx == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
                    cmd_count = cmd_count - 1'b1;
                    o.cmd_valid = 1'b1;
                    o.accepted  = 1'b1;
                    o.status    = ST_OK;
                end
            end
        endcase
        o.light_on    = session_on;
        o.queue_level = LEVEL_W'(cmd_count);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        outcome_t want;
        outcome_t got;
        if (!rst_n) begin
            errors        = 0;
            session_on    = 1'b0;
            session_start = '0;
            restore_level = '0;
            rd_idx        = '0;
            wr_idx        = '0;
            cmd_count     = '0;
            lim_batt      = RST_MIN_BATT;
            lim_tmin      = RST_MIN_TEMP;
            lim_tmax      = RST_MAX_TEMP;
            lim_on        = RST_MAX_ON;
            outcomes_due.delete();
        end else begin
            if (res.valid && res.ready) begin
                got.accepted       = res.accepted;
                got.status         = status_t'(res.status);
                got.light_on       = res.light_on;
                got.cmd_valid      = res.cmd_valid;
                got.cmd_brightness = res.cmd_brightness;
                got.queue_level    = res.queue_level;
                if (outcomes_due.size() == 0)
                    report_mismatch("result word with no event waiting");
                else begin
                    want = outcomes_due.pop_front();
                    check_field("accepted", got.accepted, want.accepted);
                    check_field("status", got.status, want.status);
                    check_field("light_on", got.light_on, want.light_on);
                    check_field("cmd_valid", got.cmd_valid, want.cmd_valid);
                    check_field("cmd_brightness", got.cmd_brightness, want.cmd_brightness);
                    check_field("queue_level", got.queue_level, want.queue_level);
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg_reg_t'(cfg.index))
                    CR_MIN_BATT: lim_batt = cfg.data[BATT_W-1:0];
                    CR_MIN_TEMP: lim_tmin = cfg.data[TEMP_W-1:0];
                    CR_MAX_TEMP: lim_tmax = cfg.data[TEMP_W-1:0];
                    default:     lim_on   = cfg.data[TIME_W-1:0];
                endcase
            end
            if (evt.valid && evt.ready) begin
                predict_event(kind_t'(evt.kind), evt.now_ms, evt.charge_pct,
                              evt.temp_deg, evt.power_valid,
                              evt.brightness_to_restore, want);
                outcomes_due.push_back(want);
            end
        end
        pending = outcomes_due.size();
    end

endmodule

### tb/sv/timed_light_session_with_command_fifo_unit_tb.sv
// Top of the light session testbench: clock, reset, stimulus, idling and the verdict.
module timed_light_session_with_command_fifo_unit_tb;
    import tlsc_pkg::*;

    localparam int STALL_LIMIT     = 2000;  // cycles with no word moving on any channel
    localparam int HOLD_OFF_CYCLES = 64;    // long receiver stall, fills the block
    localparam int PHASE_ITEMS     = 240;
    localparam int PHASES          = 6;

    typedef struct packed {
        kind_t                      kind;
        logic [TIME_W-1:0]          now_ms;
        logic [BATT_W-1:0]          battery;
        logic signed [TEMP_W-1:0]   temp;
        logic                       power;
        logic [BRIGHT_W-1:0]        restore;
    } light_event_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tlsc_evt_if evt ();
    tlsc_res_if res ();
    tlsc_cfg_if cfg ();

    int fail_count;
    int words_due;

    timed_light_session_with_command_fifo_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg)
    );

    tlsc_outcome_checker outcome_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .res     (res),
        .cfg     (cfg),
        .errors  (fail_count),
        .pending (words_due)
    );

    // idle rates in percent, changed per phase by the stimulus process
    int send_idle_pct = 33;
    int recv_idle_pct = 72;
    bit hold_req      = 1'b0;

    // stimulus-side copy of the limits, only used to aim the random words
    int                batt_floor = 10;
    int                temp_lo    = 0;
    int                temp_hi    = 45;
    logic [TIME_W-1:0] on_limit   = 32'd60000;

    // running time stamp and time of the last start word offered
    logic [TIME_W-1:0] t_now      = '0;
    logic [TIME_W-1:0] last_start = '0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result receiver. A hold request from the stimulus side drops ready for a
    // long stretch that this process counts itself; the sender keeps offering.
    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else
                res.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if ((evt.valid && evt.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timed_light_session_with_command_fifo_unit_tb: done, errors");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic light_event_t mk_event(input kind_t k, input logic [TIME_W-1:0] now,
                                              input int batt, input int temp,
                                              input bit pwr, input int restore);
        light_event_t e;
        e.kind    = k;
        e.now_ms  = now;
        e.battery = BATT_W'(batt);
        e.temp    = TEMP_W'(temp);
        e.power   = pwr;
        e.restore = BRIGHT_W'(restore);
        return e;
    endfunction

    // Offer one event word; random idle cycles go in front of it. Valid stays
    // high from one word to the next when there is no gap.
    task automatic offer(input light_event_t e);
        while ($urandom_range(99) < send_idle_pct) begin
            evt.valid <= 1'b0;
            @(posedge clk);
        end
        evt.valid                 <= 1'b1;
        evt.kind                  <= e.kind;
        evt.now_ms                <= e.now_ms;
        evt.charge_pct            <= e.battery;
        evt.temp_deg              <= e.temp;
        evt.power_valid           <= e.power;
        evt.brightness_to_restore <= e.restore;
        @(posedge clk);
        while (!evt.ready) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
    endtask

    // Writes all four limits back to back; only called while the block is idle.
    task automatic program_limits(input int batt, input int tlo, input int thi,
                                  input logic [TIME_W-1:0] on_ms);
        batt_floor = batt;
        temp_lo    = tlo;
        temp_hi    = thi;
        on_limit   = on_ms;
        write_reg(CR_MIN_BATT, CFG_DATA_W'(batt));
        write_reg(CR_MIN_TEMP, {24'd0, 8'(tlo)});
        write_reg(CR_MAX_TEMP, {24'd0, 8'(thi)});
        write_reg(CR_MAX_ON, on_ms);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait at falling edges until every result word is back.
    task automatic drain_results();
        evt.valid <= 1'b0;
        @(negedge clk);
        while (words_due != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Random word. Mostly well-formed session traffic aimed at the current
    // limits; a few words are pure noise. take_pct sets how fast the command
    // queue drains, so some bursts fill it and others run it dry.
    task automatic draw_event(input int take_pct, output light_event_t e);
        int r;
        r = $urandom_range(99);
        if (r < 5)
            t_now = $urandom();
        else if (r < 15)
            t_now = t_now + on_limit;
        else
            t_now = t_now + ($urandom() % ((on_limit >> 2) + 32'd2));

        e.now_ms  = t_now;
        e.battery = BATT_W'($urandom_range(100));
        e.temp    = TEMP_W'($urandom());
        e.power   = 1'($urandom_range(1));
        e.restore = BRIGHT_W'($urandom());

        if ($urandom_range(99) < 5) begin
            e.kind = kind_t'($urandom_range(3));
        end else if ($urandom_range(99) < take_pct) begin
            e.kind = EV_TAKE;
        end else begin
            r = $urandom_range(99);
            if (r < 35) begin
                e.kind     = EV_START;
                last_start = t_now;
                e.power    = ($urandom_range(19) != 0);
                if ($urandom_range(9) < 8 && batt_floor <= 100)
                    e.battery = BATT_W'($urandom_range(100, batt_floor));
                if ($urandom_range(9) < 8 && temp_lo <= temp_hi)
                    e.temp = TEMP_W'(temp_lo + int'($urandom_range(temp_hi - temp_lo)));
            end else if (r < 80) begin
                e.kind = EV_TICK;
                // land right on the timeout boundary or one short of it
                if ($urandom_range(4) == 0)
                    e.now_ms = last_start + on_limit - TIME_W'($urandom_range(1));
            end else
                e.kind = EV_STOP;
        end
    endtask

    initial begin
        light_event_t e;
        int           take_pct;
        int           b;
        int           ta;
        int           tb;

        evt.valid                 <= 1'b0;
        evt.kind                  <= '0;
        evt.now_ms                <= '0;
        evt.charge_pct            <= '0;
        evt.temp_deg              <= '0;
        evt.power_valid           <= 1'b0;
        evt.brightness_to_restore <= '0;
        cfg.valid                 <= 1'b0;
        cfg.index                 <= '0;
        cfg.data                  <= '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset limits: battery 10, 0..45 C, 60000 ms.
        offer(mk_event(EV_TAKE,  32'd0, 0, 0, 1'b0, 0));     // take on empty queue
        offer(mk_event(EV_TICK,  32'd5, 0, 0, 1'b0, 0));     // tick with no session
        offer(mk_event(EV_STOP,  32'd9, 0, 0, 1'b0, 0));     // stop with no session
        offer(mk_event(EV_START, 32'd10, 0, -128, 1'b0, 255)); // power first
        offer(mk_event(EV_START, 32'd11, 9, 20, 1'b1, 1));   // battery one below
        offer(mk_event(EV_START, 32'd12, 100, 127, 1'b1, 2)); // too hot
        offer(mk_event(EV_START, 32'd13, 10, -1, 1'b1, 3));  // one below the window
        // session across the 32-bit wrap, top of the window
        offer(mk_event(EV_START, 32'hFFFF_FFF0, 100, 45, 1'b1, 0));
        offer(mk_event(EV_START, 32'hFFFF_FFF1, 100, 45, 1'b1, 7));  // already running
        offer(mk_event(EV_TICK,  32'hFFFF_FFF0 + 32'd59999, 0, 0, 1'b0, 0));
        offer(mk_event(EV_TICK,  32'hFFFF_FFF0 + 32'd60000, 0, 0, 1'b0, 0));
        offer(mk_event(EV_START, 32'd0, 10, 0, 1'b1, 255));  // bottom of the window
        offer(mk_event(EV_STOP,  32'd100, 0, 0, 1'b0, 0));
        offer(mk_event(EV_TAKE,  32'd101, 0, 0, 1'b0, 0));
        // fill the command queue
        offer(mk_event(EV_START, 32'd200, 50, 20, 1'b1, 8'hAA));
        offer(mk_event(EV_STOP,  32'd201, 0, 0, 1'b0, 0));
        offer(mk_event(EV_START, 32'd300, 50, 20, 1'b1, 8'h55));
        offer(mk_event(EV_STOP,  32'd301, 0, 0, 1'b0, 0));
        offer(mk_event(EV_START, 32'd400, 50, 20, 1'b1, 8'h0F));  // last free slot
        offer(mk_event(EV_START, 32'd401, 50, 20, 1'b1, 8'hF0));  // running wins over full
        offer(mk_event(EV_STOP,  32'd402, 0, 0, 1'b0, 0));        // ends with queue full
        offer(mk_event(EV_START, 32'd500, 50, 20, 1'b1, 8'h11));  // refused, queue full
        offer(mk_event(EV_TAKE,  32'd501, 0, 0, 1'b0, 0));
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            // idling: sender light/receiver heavy, then swapped, then none
            if (ph < 2) begin
                send_idle_pct = 33;
                recv_idle_pct = 72;
            end else if (ph < 4) begin
                send_idle_pct = 72;
                recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            ta = $urandom_range(255) - 128;
            tb = $urandom_range(255) - 128;
            if (ta > tb) begin
                b  = ta;
                ta = tb;
                tb = b;
            end
            case (ph)
                0: program_limits(0, -128, 127, 32'd0);        // zero length: any tick ends
                1: program_limits(100, 127, 127, 32'hFFFF_FFFF);
                2: program_limits($urandom_range(100), -128, -128, 32'd1);
                3: program_limits($urandom_range(100), ta, tb, $urandom_range(5000, 1));
                4: program_limits(50, -20, 60, 32'd1000);
                default: program_limits($urandom_range(100), ta, tb, $urandom() | 32'd1);
            endcase

            // long receiver stall while the sender keeps pushing
            if (ph == 4)
                hold_req = 1'b1;

            take_pct = 25;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 32 == 0) begin
                    case ($urandom_range(2))
                        0:       take_pct = 5;
                        1:       take_pct = 25;
                        default: take_pct = 60;
                    endcase
                end
                draw_event(take_pct, e);
                offer(e);
            end
            drain_results();
        end

        // catch any stray result word after the last expected one
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("timed_light_session_with_command_fifo_unit_tb: done, clean");
        else
            $display("timed_light_session_with_command_fifo_unit_tb: done, errors");
        $finish;
    end

endmodule
